// ===== sv/sfc_pkg.sv =====
`default_nettype none

package sfc_pkg;

  // field widths and frame geometry
  localparam int unsigned ByteW   = 8;
  localparam int unsigned FrameLen = 8;
  localparam int unsigned CountW  = $clog2(FrameLen);
  localparam int unsigned CfgIdxW = 8;

  // register reset values
  localparam logic [ByteW-1:0] HeaderReset = 8'h55;
  localparam logic [ByteW-1:0] TailReset   = 8'hBB;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegHeader = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegTail   = CfgIdxW'(1);

  // byte counter codes
  localparam logic [CountW-1:0] CountIdle  = CountW'(0);
  localparam logic [CountW-1:0] CountFirst = CountW'(1);
  localparam logic [CountW-1:0] CountLast  = CountW'(FrameLen - 1);

  // frame status codes
  typedef enum logic [1:0] {
    StatusNone    = 2'd0,
    StatusGood    = 2'd1,
    StatusBadTail = 2'd2,
    StatusBadSum  = 2'd3
  } status_e;

  // outcome of the frame check for one item
  typedef struct packed {
    logic    frame_end;
    status_e status;
  } check_t;

endpackage

`default_nettype wire

// ===== sv/sfc_frame_check.sv =====
`default_nettype none

module sfc_frame_check (
  input  wire logic [sfc_pkg::CountW-1:0]   count_i,
  input  wire logic [sfc_pkg::ByteW-1:0]    rx_byte_i,
  input  wire logic [sfc_pkg::ByteW-1:0]    tail_value_i,
  input  wire logic [3:0][sfc_pkg::ByteW-1:0] data_i,
  input  wire logic [sfc_pkg::ByteW-1:0]    check_i,
  output sfc_pkg::check_t                   check_o
);

  logic [sfc_pkg::ByteW-1:0] sum;

  // mod-256 sum of the four data bytes
  assign sum = data_i[0] + data_i[1] + data_i[2] + data_i[3];

  // tail is checked first, then the checksum
  always_comb begin
    check_o.frame_end = 1'b0;
    check_o.status    = sfc_pkg::StatusNone;
    if (count_i == sfc_pkg::CountLast) begin
      check_o.frame_end = 1'b1;
      if (rx_byte_i != tail_value_i) begin
        check_o.status = sfc_pkg::StatusBadTail;
      end else if (sum != check_i) begin
        check_o.status = sfc_pkg::StatusBadSum;
      end else begin
        check_o.status = sfc_pkg::StatusGood;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/serial_frame_checker.sv =====
// Serial frame checker: takes one received byte per item and returns one result item per
// byte. An idle block waits for the header byte, then stores the next six bytes; the
// eighth byte ends the frame and is checked against the tail value, and byte 6 against the
// mod-256 sum of bytes 2 to 5. A new byte is accepted in every cycle unless a held result
// is stalled; results sit in a single output register, one item per cycle while the
// output side takes results. The configuration port is always ready; the user must write
// header and tail values through it only while idle; the block does not enforce this.
`default_nettype none

module serial_frame_checker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sfc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [sfc_pkg::ByteW-1:0]     cfg_data_i,
  // received bytes
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [sfc_pkg::ByteW-1:0]     rx_byte_i,
  // results
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               frame_end_o,
  output logic [1:0]                         status_o,
  output logic                               valid_flag_o,
  output logic                               alarm_o,
  output logic                               received_sticky_o,
  output logic [sfc_pkg::ByteW-1:0]          command_byte_o,
  output logic [sfc_pkg::ByteW-1:0]          data_zero_o,
  output logic [sfc_pkg::ByteW-1:0]          data_one_o,
  output logic [sfc_pkg::ByteW-1:0]          data_two_o,
  output logic [sfc_pkg::ByteW-1:0]          data_three_o,
  output logic [sfc_pkg::ByteW-1:0]          check_byte_o
);

  logic [sfc_pkg::ByteW-1:0]  header_q, tail_q;
  logic [sfc_pkg::CountW-1:0] count_q, count_d;
  logic [sfc_pkg::ByteW-1:0]  store_q [1:6];
  logic                       ok_q, ok_d;
  logic                       alarm_q, alarm_d;
  logic                       sticky_q, sticky_d;
  logic                       out_valid_q;
  logic                       in_accept;
  logic [3:0][sfc_pkg::ByteW-1:0] data;
  sfc_pkg::check_t            check;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= sfc_pkg::HeaderReset;
      tail_q   <= sfc_pkg::TailReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sfc_pkg::RegHeader: header_q <= cfg_data_i;
        sfc_pkg::RegTail:   tail_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake: take a byte whenever the result register is free or draining
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // frame check on the incoming byte
  assign data = {store_q[5], store_q[4], store_q[3], store_q[2]};

  sfc_frame_check u_check (
    .count_i      (count_q),
    .rx_byte_i    (rx_byte_i),
    .tail_value_i (tail_q),
    .data_i       (data),
    .check_i      (store_q[6]),
    .check_o      (check)
  );

  // next counter and flag values
  always_comb begin
    count_d  = count_q;
    ok_d     = ok_q;
    alarm_d  = alarm_q;
    sticky_d = sticky_q;
    if (count_q == sfc_pkg::CountLast) begin
      count_d = sfc_pkg::CountIdle;
    end else if (count_q != sfc_pkg::CountIdle) begin
      count_d = count_q + sfc_pkg::CountW'(1);
    end else if (rx_byte_i == header_q) begin
      count_d = sfc_pkg::CountFirst;
    end
    if (check.frame_end) begin
      if (check.status == sfc_pkg::StatusGood) begin
        ok_d     = 1'b1;
        alarm_d  = 1'b0;
        sticky_d = 1'b1;
      end else begin
        ok_d    = 1'b0;
        alarm_d = 1'b1;
      end
    end
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= sfc_pkg::CountIdle;
      ok_q     <= 1'b0;
      alarm_q  <= 1'b0;
      sticky_q <= 1'b0;
      for (int i = 1; i <= 6; i++) begin
        store_q[i] <= '0;
      end
    end else if (in_accept) begin
      count_q  <= count_d;
      ok_q     <= ok_d;
      alarm_q  <= alarm_d;
      sticky_q <= sticky_d;
      // bytes 1 to 6 are kept; the header and tail are not needed later
      if (count_q != sfc_pkg::CountIdle && count_q != sfc_pkg::CountLast) begin
        store_q[count_q] <= rx_byte_i;
      end
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, shows the store after this byte
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      frame_end_o       <= check.frame_end;
      status_o          <= check.status;
      valid_flag_o      <= ok_d;
      alarm_o           <= alarm_d;
      received_sticky_o <= sticky_d;
      command_byte_o    <= (count_q == sfc_pkg::CountW'(1)) ? rx_byte_i : store_q[1];
      data_zero_o       <= (count_q == sfc_pkg::CountW'(2)) ? rx_byte_i : store_q[2];
      data_one_o        <= (count_q == sfc_pkg::CountW'(3)) ? rx_byte_i : store_q[3];
      data_two_o        <= (count_q == sfc_pkg::CountW'(4)) ? rx_byte_i : store_q[4];
      data_three_o      <= (count_q == sfc_pkg::CountW'(5)) ? rx_byte_i : store_q[5];
      check_byte_o      <= (count_q == sfc_pkg::CountW'(6)) ? rx_byte_i : store_q[6];
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
